FILE: rtl/dltm_pkg.sv
// Shared constants, types and codes of the device list tolerance matcher.
package dltm_pkg;

	// Table capacity and the widths that follow from it.
	localparam int MAX_DEVICES = 32;
	localparam int IDX_W       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int CNT_W       = $clog2(MAX_DEVICES + 1);

	// Fixed field widths.
	localparam int VAL_W     = 20;
	localparam int TOL_W     = 7;
	localparam int FLOOR_W   = 10;
	localparam int PROD_W    = 27;
	localparam int ENTRY_W   = 5;
	localparam int MATCH_W   = 6;
	localparam int LAYOUT_W  = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 10;

	// Operation codes of an input item.
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_CHECK  = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// Kinds of result item.
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_CHECK   = 2'd1;
	localparam logic [1:0] KIND_MISSING = 2'd2;
	localparam logic [1:0] KIND_SUMMARY = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 1'b1;

	// Request to the shared tolerance unit.
	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} tol_req_t;

	// Answer of the shared tolerance unit.
	typedef struct packed {
		logic done;
		logic ok;
	} tol_rsp_t;

endpackage

FILE: rtl/dltm_tol_unit.sv
// Two-stage tolerance compare unit shared by the width and length checks.
module dltm_tol_unit import dltm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tol_req_t           req,
	input  logic [TOL_W-1:0]   tolerance_percent,
	input  logic [FLOOR_W-1:0] floor_tolerance_nm,
	output tol_rsp_t           rsp
);

	logic               v_s1;
	logic [VAL_W-1:0]   hi_s1;
	logic [VAL_W-1:0]   err_s1;
	logic               v_s2;
	logic [VAL_W-1:0]   err_s2;
	logic [PROD_W-1:0]  scaled_s2;
	logic [PROD_W-1:0]  err100_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
		end
	end

	// First stage: larger value and absolute difference.
	always_ff @(posedge clk) begin
		if (req.a > req.b) begin
			hi_s1  <= req.a;
			err_s1 <= req.a - req.b;
		end else begin
			hi_s1  <= req.b;
			err_s1 <= req.b - req.a;
		end
	end

	// Second stage: scaled tolerance and scaled error.
	always_ff @(posedge clk) begin
		err_s2    <= err_s1;
		scaled_s2 <= PROD_W'(tolerance_percent) * PROD_W'(hi_s1);
		err100_s2 <= PROD_W'(err_s1) * PROD_W'(100);
	end

	// The floor applies only when the scaled tolerance comes out zero.
	always_comb begin
		rsp.done = v_s2;
		if (scaled_s2 == '0) begin
			rsp.ok = (err_s2 <= VAL_W'(floor_tolerance_nm));
		end else begin
			rsp.ok = (err100_s2 <= scaled_s2);
		end
	end

endmodule

FILE: rtl/device_list_tolerance_matcher.sv
// Top level of the device list tolerance matcher: table, sequencer and result port.
//
// An item is accepted at a clock edge where start is high and busy is low.
// A load item writes the next free table slot and shows its acknowledge on
// the result ports in the very next cycle; busy stays low, so loads can
// follow back to back. A check item raises busy and scans the loaded slots
// in ascending order. A slot that is taken or of the other type passes
// through the table read and then the select step; an eligible slot goes
// on to the shared tolerance unit for the width and, if that passes, for
// the length. The time a check keeps busy high is set by the one table
// read port and the single tolerance unit. A finish item walks the taken
// flags one slot per cycle, giving one missing-entry result per untaken
// slot, then the summary; the table is emptied as the summary goes out.
// Each result is shown for exactly one cycle with result_valid high; the
// receiver cannot stall, and the result marked last coincides with busy
// low again. Configuration writes on the cfg channel are always ready and
// are meant for idle periods. Reset empties the table, clears the counters
// and restores tolerance and floor to ten.
module device_list_tolerance_matcher import dltm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           opcode,
	input  logic                 dev_type,
	input  logic [VAL_W-1:0]     width_nm,
	input  logic [VAL_W-1:0]     length_nm,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output logic                 result_valid,
	output logic [1:0]           kind,
	output logic [ENTRY_W-1:0]   entry_index,
	output logic                 found,
	output logic                 overflow,
	output logic [MATCH_W-1:0]   matched_count,
	output logic [MATCH_W-1:0]   reference_count,
	output logic [LAYOUT_W-1:0]  layout_count,
	output logic                 all_match,
	output logic                 last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK_RD,
		S_CHK_SEL,
		S_CHK_WID,
		S_CHK_LEN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic                dev_type;
		logic [VAL_W-1:0]    width;
		logic [VAL_W-1:0]    length;
	} ref_entry_t;

	typedef struct packed {
		logic                valid;
		logic [1:0]          kind;
		logic [ENTRY_W-1:0]  entry_index;
		logic                found;
		logic                overflow;
		logic [MATCH_W-1:0]  matched_count;
		logic [MATCH_W-1:0]  reference_count;
		logic [LAYOUT_W-1:0] layout_count;
		logic                all_match;
		logic                last;
	} result_t;

	state_t                 state_q;
	result_t                res_q;
	logic [TOL_W-1:0]       tol_q;
	logic [FLOOR_W-1:0]     floor_q;
	logic [CNT_W-1:0]       fill_q;
	logic [CNT_W-1:0]       pair_q;
	logic [LAYOUT_W-1:0]    checked_q;
	logic [CNT_W-1:0]       scan_q;
	logic [MAX_DEVICES-1:0] taken_q;
	logic                   type_q;
	logic [VAL_W-1:0]       w_q;
	logic [VAL_W-1:0]       l_q;

	ref_entry_t             mem [MAX_DEVICES];
	ref_entry_t             rd_q;

	logic                   accept;
	logic                   load_wr;
	logic                   eligible;
	logic                   scan_end;
	logic [IDX_W-1:0]       scan_idx;
	tol_req_t               tol_req;
	tol_rsp_t               tol_rsp;

	// Build a result of the kinds that carry no counts.
	function automatic result_t mk_result(logic [1:0] k, logic [ENTRY_W-1:0] idx,
			logic fnd, logic ovf, logic lst);
		result_t r;
		r             = '0;
		r.valid       = 1'b1;
		r.kind        = k;
		r.entry_index = idx;
		r.found       = fnd;
		r.overflow    = ovf;
		r.last        = lst;
		return r;
	endfunction

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign scan_idx  = scan_q[IDX_W-1:0];
	assign scan_end  = (scan_q >= fill_q);
	assign load_wr   = accept && (opcode == OP_LOAD) && (fill_q < CNT_W'(MAX_DEVICES));
	assign eligible  = !taken_q[scan_idx] && (rd_q.dev_type == type_q);

	// The width check starts from the select step, the length check from a
	// passed width check; both compare the held layout values to the slot.
	always_comb begin
		tol_req.start = ((state_q == S_CHK_SEL) && eligible) ||
			((state_q == S_CHK_WID) && tol_rsp.done && tol_rsp.ok);
		if (state_q == S_CHK_SEL) begin
			tol_req.a = w_q;
			tol_req.b = rd_q.width;
		end else begin
			tol_req.a = l_q;
			tol_req.b = rd_q.length;
		end
	end

	dltm_tol_unit u_tol (
		.clk                (clk),
		.arst_n             (arst_n),
		.req                (tol_req),
		.tolerance_percent  (tol_q),
		.floor_tolerance_nm (floor_q),
		.rsp                (tol_rsp)
	);

	// Reference table: one write port for loads, one registered read port
	// that follows the scan pointer.
	always_ff @(posedge clk) begin
		if (load_wr) begin
			mem[fill_q[IDX_W-1:0]] <= '{dev_type: dev_type, width: width_nm,
				length: length_nm};
		end
		rd_q <= mem[scan_idx];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_W'(10);
			floor_q <= FLOOR_W'(10);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TOLERANCE: tol_q   <= cfg_data[TOL_W-1:0];
				CFG_FLOOR:     floor_q <= cfg_data[FLOOR_W-1:0];
				default:       ;
			endcase
		end
	end

	// Sequencer with its registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_q     <= '0;
			fill_q    <= '0;
			pair_q    <= '0;
			checked_q <= '0;
			scan_q    <= '0;
			taken_q   <= '0;
			type_q    <= 1'b0;
			w_q       <= '0;
			l_q       <= '0;
		end else begin
			res_q.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_LOAD: begin
								if (load_wr) begin
									taken_q[fill_q[IDX_W-1:0]] <= 1'b0;
									fill_q <= fill_q + CNT_W'(1);
									res_q  <= mk_result(KIND_LOAD, ENTRY_W'(fill_q),
										1'b0, 1'b0, 1'b1);
								end else begin
									res_q <= mk_result(KIND_LOAD, '0, 1'b0, 1'b1, 1'b1);
								end
							end
							OP_CHECK: begin
								if (checked_q != '1) begin
									checked_q <= checked_q + LAYOUT_W'(1);
								end
								type_q  <= dev_type;
								w_q     <= width_nm;
								l_q     <= length_nm;
								scan_q  <= '0;
								state_q <= S_CHK_RD;
							end
							OP_FINISH: begin
								scan_q  <= '0;
								state_q <= S_FIN;
							end
							default: ;
						endcase
					end
				end
				S_CHK_RD: begin
					if (scan_end) begin
						res_q   <= mk_result(KIND_CHECK, '0, 1'b0, 1'b0, 1'b1);
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CHK_SEL;
					end
				end
				S_CHK_SEL: begin
					if (eligible) begin
						state_q <= S_CHK_WID;
					end else begin
						scan_q  <= scan_q + CNT_W'(1);
						state_q <= S_CHK_RD;
					end
				end
				S_CHK_WID: begin
					if (tol_rsp.done) begin
						if (tol_rsp.ok) begin
							state_q <= S_CHK_LEN;
						end else begin
							scan_q  <= scan_q + CNT_W'(1);
							state_q <= S_CHK_RD;
						end
					end
				end
				S_CHK_LEN: begin
					if (tol_rsp.done) begin
						if (tol_rsp.ok) begin
							taken_q[scan_idx] <= 1'b1;
							if (pair_q != '1) begin
								pair_q <= pair_q + CNT_W'(1);
							end
							res_q   <= mk_result(KIND_CHECK, ENTRY_W'(scan_q), 1'b1,
								1'b0, 1'b1);
							state_q <= S_IDLE;
						end else begin
							scan_q  <= scan_q + CNT_W'(1);
							state_q <= S_CHK_RD;
						end
					end
				end
				S_FIN: begin
					if (!scan_end) begin
						if (!taken_q[scan_idx]) begin
							res_q <= mk_result(KIND_MISSING, ENTRY_W'(scan_q), 1'b0,
								1'b0, 1'b0);
						end
						scan_q <= scan_q + CNT_W'(1);
					end else begin
						res_q <= '{valid: 1'b1, kind: KIND_SUMMARY, entry_index: '0,
							found: 1'b0, overflow: 1'b0,
							matched_count: MATCH_W'(pair_q),
							reference_count: MATCH_W'(fill_q),
							layout_count: checked_q,
							all_match: (pair_q == fill_q) &&
								(LAYOUT_W'(pair_q) == checked_q),
							last: 1'b1};
						taken_q   <= '0;
						fill_q    <= '0;
						pair_q    <= '0;
						checked_q <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid    = res_q.valid;
	assign kind            = res_q.kind;
	assign entry_index     = res_q.entry_index;
	assign found           = res_q.found;
	assign overflow        = res_q.overflow;
	assign matched_count   = res_q.matched_count;
	assign reference_count = res_q.reference_count;
	assign layout_count    = res_q.layout_count;
	assign all_match       = res_q.all_match;
	assign last            = res_q.last;

	// A load is acknowledged in the cycle right after it is accepted.
	a_load_ack: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (opcode == OP_LOAD) |=>
			result_valid && (kind == KIND_LOAD) && last)
		else $error("load item not acknowledged in the next cycle");

	// The final result of an item goes out as the block turns idle again.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("final result shown while still busy");

	// Missing-entry results only come out of the finish walk.
	a_missing_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy && (kind == KIND_MISSING))
		else $error("non-final result outside the finish walk");

	// The fill count never goes beyond the table capacity.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_DEVICES))
		else $error("table fill count beyond capacity");

endmodule

FILE: dv/device_list_tolerance_matcher_tb.sv
// Self-checking testbench of the device list tolerance matcher: table loads, tolerance checks, finish reports.
module device_list_tolerance_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dltm_pkg::*;

	// Opcode 3 has no meaning; the block must ignore it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [VAL_W-1:0] VMAX = '1;

	// Quiet cycles before a register write. This outlasts even a full-table
	// check, and an ignored opcode leaves nothing to wait on, so this covers
	// any work still in flight with margin.
	localparam int SETTLE_CYCLES = 300;

	// Run limit, well above the slowest correct run (every check a full-table
	// scan, long sender gaps and the quiet periods before register writes).
	localparam int LIMIT_CYCLES = 1_000_000;

	// Number of input items the plan aims at over the whole run.
	localparam int MIXED_ITEMS = 420;

	typedef enum logic [1:0] {
		STEP_ITEM,
		STEP_CONFIG,
		STEP_PAUSE
	} step_kind_t;

	// One entry of the stimulus plan: an input item, a register write, or a
	// pause until every awaited result has come back.
	typedef struct {
		step_kind_t           what;
		logic [1:0]           op;
		logic                 ty;
		logic [VAL_W-1:0]     w;
		logic [VAL_W-1:0]     l;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_DAT_W-1:0] reg_dat;
		int                   idle_pct;
	} step_t;

	// One result as the block should present it.
	typedef struct {
		logic [1:0]          rkind;
		logic [ENTRY_W-1:0]  idx;
		logic                found;
		logic                ovf;
		logic [MATCH_W-1:0]  matched;
		logic [MATCH_W-1:0]  refs;
		logic [LAYOUT_W-1:0] layout;
		logic                all_match;
		logic                last;
	} result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           opcode = OP_LOAD;
	logic                 dev_type = 1'b0;
	logic [VAL_W-1:0]     width_nm = '0;
	logic [VAL_W-1:0]     length_nm = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TOLERANCE;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 result_valid;
	logic [1:0]           kind;
	logic [ENTRY_W-1:0]   entry_index;
	logic                 found;
	logic                 overflow;
	logic [MATCH_W-1:0]   matched_count;
	logic [MATCH_W-1:0]   reference_count;
	logic [LAYOUT_W-1:0]  layout_count;
	logic                 all_match;
	logic                 last;

	step_t   pending_requests[$];
	result_t awaited_results[$];

	// Handshake flags seen at the rising edge, used by the driver at the
	// following falling edge.
	logic item_taken = 1'b0;
	logic cfg_taken = 1'b0;
	int   settle_cycles = 0;
	int   failures = 0;

	// Predictor state: the reference table, the counters and the two
	// tolerance registers, all at their reset values.
	logic             tab_type[MAX_DEVICES];
	logic [VAL_W-1:0] tab_width[MAX_DEVICES];
	logic [VAL_W-1:0] tab_length[MAX_DEVICES];
	logic             tab_taken[MAX_DEVICES] = '{default: 1'b0};
	int               tab_fill = 0;
	int               pairs = 0;
	int               checked = 0;
	logic [TOL_W-1:0]   tol_pct = TOL_W'(10);
	logic [FLOOR_W-1:0] floor_nm = FLOOR_W'(10);

	// Stimulus planning: the tolerance the plan expects to be in force, so that
	// near-miss checks can be aimed at the edge of the window, and a shadow of
	// the devices loaded in the current list.
	int               plan_tol = 10;
	int               plan_floor = 10;
	int               planned_items = 0;
	logic             plan_type[$];
	logic [VAL_W-1:0] plan_width[$];
	logic [VAL_W-1:0] plan_length[$];

	device_list_tolerance_matcher dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.dev_type        (dev_type),
		.width_nm        (width_nm),
		.length_nm       (length_nm),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.result_valid    (result_valid),
		.kind            (kind),
		.entry_index     (entry_index),
		.found           (found),
		.overflow        (overflow),
		.matched_count   (matched_count),
		.reference_count (reference_count),
		.layout_count    (layout_count),
		.all_match       (all_match),
		.last            (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Reset is released on a falling edge, away from any sampling edge.
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("device_list_tolerance_matcher_tb NOT OK");
		$finish;
	end

	// Exact integer tolerance test: the difference may be at most the given
	// percentage of the larger value; when that scaled value is zero the
	// absolute floor applies instead.
	function automatic bit within_tolerance(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned scaled;
		hi = 64'((a > b) ? a : b);
		lo = 64'((a > b) ? b : a);
		scaled = 64'(tol_pct) * hi;
		if (scaled == 0)
			return (hi - lo) <= 64'(floor_nm);
		return (hi - lo) * 100 <= scaled;
	endfunction

	// Works out every result that one accepted item causes and appends them
	// to the awaited results, updating the table and counters on the way.
	task automatic compute_matcher_results(logic [1:0] op, logic ty,
			logic [VAL_W-1:0] w, logic [VAL_W-1:0] l);
		result_t r;
		bit      hit;
		r = '{default: '0};
		hit = 1'b0;
		case (op)
		OP_LOAD: begin
			r.rkind = KIND_LOAD;
			r.last = 1'b1;
			if (tab_fill < MAX_DEVICES) begin
				tab_type[tab_fill] = ty;
				tab_width[tab_fill] = w;
				tab_length[tab_fill] = l;
				tab_taken[tab_fill] = 1'b0;
				r.idx = ENTRY_W'(tab_fill);
				tab_fill++;
			end else begin
				// Full table: the load is turned away and nothing changes.
				r.ovf = 1'b1;
			end
			awaited_results = {awaited_results, r};
		end
		OP_CHECK: begin
			r.rkind = KIND_CHECK;
			r.last = 1'b1;
			if (checked < 65535)
				checked++;
			// Greedy: the lowest free slot of the same type that fits wins.
			for (int j = 0; j < tab_fill && !hit; j++) begin
				if (!tab_taken[j] && tab_type[j] == ty && within_tolerance(w, tab_width[j])
						&& within_tolerance(l, tab_length[j])) begin
					hit = 1'b1;
					tab_taken[j] = 1'b1;
					pairs++;
					r.found = 1'b1;
					r.idx = ENTRY_W'(j);
				end
			end
			awaited_results = {awaited_results, r};
		end
		OP_FINISH: begin
			// One report per loaded slot that never found a partner, then the
			// summary, then the list starts over empty.
			for (int j = 0; j < tab_fill; j++) begin
				if (!tab_taken[j]) begin
					r = '{default: '0};
					r.rkind = KIND_MISSING;
					r.idx = ENTRY_W'(j);
					awaited_results = {awaited_results, r};
				end
			end
			r = '{default: '0};
			r.rkind = KIND_SUMMARY;
			r.matched = MATCH_W'(pairs);
			r.refs = MATCH_W'(tab_fill);
			r.layout = LAYOUT_W'(checked);
			r.all_match = (pairs == tab_fill) && (pairs == checked);
			r.last = 1'b1;
			awaited_results = {awaited_results, r};
			tab_taken = '{default: 1'b0};
			tab_fill = 0;
			pairs = 0;
			checked = 0;
		end
		default: begin
			// The unused opcode is dropped without a trace.
		end
		endcase
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// Monitor and predictor. Results shown at this edge belong to items
	// accepted earlier, so they are checked before this edge's item is
	// predicted.
	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (awaited_results.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual kind %0d entry %0d",
						$time, kind, entry_index);
					failures++;
				end else begin
					want = awaited_results.pop_front();
					check_field("kind", 32'(want.rkind), 32'(kind));
					check_field("entry_index", 32'(want.idx), 32'(entry_index));
					check_field("found", 32'(want.found), 32'(found));
					check_field("overflow", 32'(want.ovf), 32'(overflow));
					check_field("matched_count", 32'(want.matched), 32'(matched_count));
					check_field("reference_count", 32'(want.refs), 32'(reference_count));
					check_field("layout_count", 32'(want.layout), 32'(layout_count));
					check_field("all_match", 32'(want.all_match), 32'(all_match));
					check_field("last", 32'(want.last), 32'(last));
				end
			end
			item_taken <= start && !busy;
			cfg_taken <= cfg_valid && cfg_ready;
			if (start && !busy)
				compute_matcher_results(opcode, dev_type, width_nm, length_nm);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TOLERANCE)
					tol_pct = cfg_data[TOL_W-1:0];
				else
					floor_nm = cfg_data[FLOOR_W-1:0];
			end
		end
	end

	// Driver. Works through the plan one entry at a time on falling edges.
	// Start and cfg_valid each get exactly one assignment per edge, so an
	// item that follows right after an accepted one keeps start high.
	always @(negedge clk) begin : drive
		step_t head;
		logic  nxt_start;
		logic  nxt_cfg;
		nxt_start = start;
		nxt_cfg = cfg_valid;
		if (start && item_taken) begin
			void'(pending_requests.pop_front());
			nxt_start = 1'b0;
		end
		if (cfg_valid && cfg_taken) begin
			void'(pending_requests.pop_front());
			nxt_cfg = 1'b0;
		end
		if (arst_n && !nxt_start && !nxt_cfg && pending_requests.size() != 0) begin
			head = pending_requests[0];
			case (head.what)
			STEP_ITEM: begin
				// The sender holds back at random before offering an item.
				if ($urandom_range(99, 0) >= head.idle_pct) begin
					nxt_start = 1'b1;
					opcode <= head.op;
					dev_type <= head.ty;
					width_nm <= head.w;
					length_nm <= head.l;
				end
			end
			STEP_CONFIG: begin
				// Registers change only once the block has been quiet long
				// enough that no scan can still be running.
				if (awaited_results.size() == 0 && !busy) begin
					if (settle_cycles >= SETTLE_CYCLES) begin
						settle_cycles = 0;
						nxt_cfg = 1'b1;
						cfg_index <= head.reg_idx;
						cfg_data <= head.reg_dat;
					end else begin
						settle_cycles++;
					end
				end else begin
					settle_cycles = 0;
				end
			end
			default: begin
				if (awaited_results.size() == 0)
					void'(pending_requests.pop_front());
			end
			endcase
		end
		start <= nxt_start;
		cfg_valid <= nxt_cfg;
	end

	// Appends one input item to the plan. The sender idles with a chance of 7
	// percent at first, then of 70 percent, and finally not at all.
	task automatic push_item(logic [1:0] op, logic ty, logic [VAL_W-1:0] w, logic [VAL_W-1:0] l);
		step_t s;
		s = '{what: STEP_ITEM, op: op, ty: ty, w: w, l: l, reg_idx: CFG_TOLERANCE,
			reg_dat: '0, idle_pct: 0};
		s.idle_pct = (planned_items < 160) ? 7 : (planned_items < 300) ? 70 : 0;
		if (op != OP_UNUSED)
			planned_items++;
		pending_requests = {pending_requests, s};
		if (op == OP_LOAD && plan_width.size() < MAX_DEVICES) begin
			plan_type = {plan_type, ty};
			plan_width = {plan_width, w};
			plan_length = {plan_length, l};
		end
		if (op == OP_FINISH) begin
			plan_type.delete();
			plan_width.delete();
			plan_length.delete();
		end
	endtask

	// Writes both registers. The spare upper data bits of the tolerance write
	// carry random values; only the low seven bits count.
	task automatic push_config(int tol, int flr);
		step_t s;
		s = '{what: STEP_CONFIG, op: OP_LOAD, ty: 1'b0, w: '0, l: '0, reg_idx: CFG_TOLERANCE,
			reg_dat: {3'($urandom_range(7, 0)), TOL_W'(tol)}, idle_pct: 0};
		pending_requests = {pending_requests, s};
		s.reg_idx = CFG_FLOOR;
		s.reg_dat = CFG_DAT_W'(flr);
		pending_requests = {pending_requests, s};
		plan_tol = tol;
		plan_floor = flr;
	endtask

	task automatic push_pause();
		step_t s;
		s = '{what: STEP_PAUSE, op: OP_LOAD, ty: 1'b0, w: '0, l: '0, reg_idx: CFG_TOLERANCE,
			reg_dat: '0, idle_pct: 0};
		pending_requests = {pending_requests, s};
	endtask

	// Device sizes: mostly modest, with zeros, values near the top of the
	// field and fully random ones mixed in.
	function automatic logic [VAL_W-1:0] pick_geometry();
		case ($urandom_range(7, 0))
		0: return '0;
		1: return VMAX - VAL_W'($urandom_range(3000, 0));
		2, 3: return VAL_W'($urandom);
		default: return VAL_W'($urandom_range(2000, 0));
		endcase
	endfunction

	// A value close to v: mostly inside the planned tolerance window, with a
	// slice just beyond its edge.
	function automatic logic [VAL_W-1:0] near_value(logic [VAL_W-1:0] v);
		longint span;
		longint d;
		longint r;
		span = (longint'(v) * longint'(plan_tol)) / 100;
		if (span == 0)
			span = longint'(plan_floor);
		d = longint'($urandom_range(int'(span + span / 8 + 1), 0));
		r = $urandom_range(1, 0) ? longint'(v) + d : longint'(v) - d;
		if (r < 0)
			r = 0;
		if (r > longint'(VMAX))
			r = longint'(VMAX);
		return VAL_W'(r);
	endfunction

	initial begin : plan
		int nload;
		int nchk;
		int pick;
		int roll;
		bit first_list;

		// Directed part, starting from the reset tolerance of ten percent and
		// a ten nm floor. A finish on an empty list still gives a summary.
		push_item(OP_FINISH, 1'b0, '0, '0);
		push_item(OP_LOAD, 1'b0, 20'd1000, 20'd100);
		push_item(OP_LOAD, 1'b1, '0, '0);
		push_item(OP_LOAD, 1'b0, VMAX, VMAX);
		// Ten percent above the loaded width and length, inside the window.
		push_item(OP_CHECK, 1'b0, 20'd1100, 20'd110);
		// Both values zero, so the floor decides.
		push_item(OP_CHECK, 1'b1, '0, '0);
		// Largest field value, just inside the window.
		push_item(OP_CHECK, 1'b0, 20'd943718, VMAX);
		// Its only fitting slot is already taken: no match.
		push_item(OP_CHECK, 1'b0, 20'd1000, 20'd100);
		// Every slot matched but one check too many: the match flag stays low.
		push_item(OP_FINISH, 1'b1, VMAX, VMAX);
		// A clean list where every count agrees.
		push_item(OP_LOAD, 1'b1, 20'd1000, 20'd1000);
		push_item(OP_CHECK, 1'b1, 20'd1111, 20'd1000);
		push_item(OP_FINISH, 1'b0, '0, '0);
		// Zero percent: only the absolute floor, here at its maximum.
		push_config(0, 1023);
		push_item(OP_LOAD, 1'b0, 20'd500, 20'd500);
		push_item(OP_LOAD, 1'b0, 20'd500, 20'd500);
		push_item(OP_CHECK, 1'b0, 20'd1523, 20'd1500);
		push_item(OP_CHECK, 1'b0, 20'd1524, 20'd500);
		push_item(OP_FINISH, 1'b1, '0, '0);
		// Largest tolerance code, above a hundred percent, and a zero floor.
		push_config(127, 0);
		push_item(OP_LOAD, 1'b1, 20'd1000, 20'd1000);
		push_item(OP_UNUSED, 1'b1, VMAX, VMAX);
		push_item(OP_CHECK, 1'b0, '0, '0);
		push_item(OP_CHECK, 1'b1, 20'd1, 20'd1);
		push_item(OP_FINISH, 1'b0, VMAX, '0);
		push_pause();

		// Mixed part: whole device lists, most checks aimed near a loaded
		// device, with random checks, late loads and ignored opcodes mixed in.
		first_list = 1'b1;
		while (planned_items < MIXED_ITEMS) begin
			if ($urandom_range(3, 0) == 0) begin
				case ($urandom_range(5, 0))
				0: push_config(0, $urandom_range(1023, 0));
				1: push_config(100, $urandom_range(1, 0) ? 0 : 1023);
				2: push_config($urandom_range(127, 101), $urandom_range(1023, 0));
				3: push_config(10, 10);
				default: push_config($urandom_range(127, 0), $urandom_range(1023, 0));
				endcase
			end
			if ($urandom_range(7, 0) == 0)
				push_pause();
			// The first list overruns the table; others now and then come near it.
			if (first_list)
				nload = MAX_DEVICES + 2;
			else if ($urandom_range(7, 0) == 0)
				nload = $urandom_range(MAX_DEVICES + 4, MAX_DEVICES - 4);
			else
				nload = $urandom_range(8, 0);
			first_list = 1'b0;
			for (int i = 0; i < nload; i++)
				push_item(OP_LOAD, 1'($urandom), pick_geometry(), pick_geometry());
			nchk = $urandom_range(nload + 2, 0);
			for (int i = 0; i < nchk; i++) begin
				roll = $urandom_range(99, 0);
				if (roll < 3) begin
					push_item(OP_UNUSED, 1'($urandom), VAL_W'($urandom), VAL_W'($urandom));
				end else if (roll < 8) begin
					push_item(OP_LOAD, 1'($urandom), pick_geometry(), pick_geometry());
				end else if (roll < 80 && plan_width.size() != 0) begin
					pick = $urandom_range(plan_width.size() - 1, 0);
					push_item(OP_CHECK, ($urandom_range(9, 0) == 0) ? !plan_type[pick] : plan_type[pick],
						near_value(plan_width[pick]), near_value(plan_length[pick]));
				end else begin
					push_item(OP_CHECK, 1'($urandom), pick_geometry(), pick_geometry());
				end
			end
			push_item(OP_FINISH, 1'($urandom), VAL_W'($urandom), VAL_W'($urandom));
		end

		// Wait for the plan to empty and every result to arrive, then allow a
		// scan's worth of cycles for anything stray.
		while (pending_requests.size() != 0 || awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("device_list_tolerance_matcher_tb OK");
		else
			$display("device_list_tolerance_matcher_tb NOT OK");
		$finish;
	end

endmodule

FILE: files.f
rtl/dltm_pkg.sv
rtl/dltm_tol_unit.sv
rtl/device_list_tolerance_matcher.sv
dv/device_list_tolerance_matcher_tb.sv
